// ----- rtl/core/in_order_frame_release_unit_assert.svh -----
// ----------------------------------------------------------------------------
// In-order frame release unit: assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef IN_ORDER_FRAME_RELEASE_UNIT_ASSERT_SVH
`define IN_ORDER_FRAME_RELEASE_UNIT_ASSERT_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define IOFR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("in_order_frame_release_unit: same-cycle check failed");

// Next-cycle implication: when the antecedent holds, the consequent holds in the next cycle.
`define IOFR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("in_order_frame_release_unit: next-cycle check failed");

`endif

// ----- rtl/core/iofr_pkg.sv -----
// ----------------------------------------------------------------------------
// In-order frame release package
// Field widths, parameter defaults, status codes and sequencer states.
// ----------------------------------------------------------------------------
package iofr_pkg;

	// Fixed widths of the beat fields.
	localparam int TAG_BITS   = 16;
	localparam int FRAME_BITS = 32;

	// Defaults for the top-level parameters.
	localparam int WINDOW_DEF    = 16;
	localparam int DATA_BITS_DEF = 32;

	// Status codes carried by each result beat.
	typedef enum logic [1:0] {
		STS_RELEASED  = 2'd0,
		STS_HELD      = 2'd1,
		STS_OUTSIDE   = 2'd2,
		STS_DUPLICATE = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_READ,
		ST_EMIT,
		ST_RESULT
	} state_t;

endpackage

// ----- rtl/core/iofr_slot_mem.sv -----
// ----------------------------------------------------------------------------
// Reorder slot memory
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module iofr_slot_mem #(
	parameter int DEPTH = iofr_pkg::WINDOW_DEF,
	parameter int WIDTH = iofr_pkg::DATA_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/in_order_frame_release_unit.sv -----
// ----------------------------------------------------------------------------
// In-order frame release unit
// Reorder buffer that stores tagged frames and releases them by increasing tag.
// ----------------------------------------------------------------------------
// Usage: frames enter on the input channel (in_valid, in_stall, frame_tag,
// frame_data) in any order. Each accepted beat yields one or more result
// beats on the output channel (out_valid, out_stall, status, out_tag,
// out_data, last); last marks the final result beat of that input.
// A frame at the expected tag releases itself and every stored frame that
// follows it without a gap, one result beat per frame. A frame stored ahead
// of a gap gives one held beat; a tag at WINDOW or more past the expected
// tag, or a tag whose slot is already full, gives one reject beat.
// Timing: the block takes one input at a time. An input that gives a single
// status beat passes through the evaluate and result states before its beat
// is loaded into the output register. In a release, each frame needs a read
// state for the registered read of the slot memory and an emit state to load
// the output register. The tag adder is shared between the distance computation
// and the expected-tag increment.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits. Reset clears the expected tag, the head slot and all slot
// valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module in_order_frame_release_unit #(
	parameter int WINDOW    = iofr_pkg::WINDOW_DEF,
	parameter int DATA_BITS = iofr_pkg::DATA_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [iofr_pkg::TAG_BITS-1:0]   frame_tag,
	input  logic [iofr_pkg::FRAME_BITS-1:0] frame_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [iofr_pkg::TAG_BITS-1:0]   out_tag,
	output logic [iofr_pkg::FRAME_BITS-1:0] out_data,
	output logic                            last
);

	localparam int TAG_W      = iofr_pkg::TAG_BITS;
	localparam int FRAME_W    = iofr_pkg::FRAME_BITS;
	localparam int STORE_BITS = (DATA_BITS < FRAME_W) ? DATA_BITS : FRAME_W;
	localparam int SLOT_W     = $clog2(WINDOW);

	localparam logic [TAG_W-1:0]  WIN_TAG   = TAG_W'(WINDOW);
	localparam logic [SLOT_W:0]   WIN_EXT   = (SLOT_W + 1)'(WINDOW);
	localparam logic [SLOT_W-1:0] HEAD_LAST = SLOT_W'(WINDOW - 1);

	iofr_pkg::state_t  state_q, state_d;
	iofr_pkg::status_t pend_status_q, pend_status_d;
	iofr_pkg::status_t status_q, ld_status;

	logic [TAG_W-1:0]      expected_q;
	logic [SLOT_W-1:0]     head_q;
	logic [WINDOW-1:0]     valid_q;
	logic                  out_valid_q;
	logic [TAG_W-1:0]      tag_q;
	logic [STORE_BITS-1:0] data_q;
	logic [TAG_W-1:0]      dist_q;
	logic [TAG_W-1:0]      out_tag_q;
	logic [FRAME_W-1:0]    out_data_q;
	logic                  last_q;

	logic [TAG_W-1:0]      alu_a, alu_b, alu_sum;
	logic                  alu_cin;
	logic [SLOT_W:0]       slot_sum;
	logic [SLOT_W-1:0]     slot_idx;
	logic [SLOT_W-1:0]     head_nxt;
	logic [STORE_BITS-1:0] rd_data;
	logic                  out_free;
	logic                  accept;
	logic                  mem_we, mem_re;
	logic                  ld_out, ld_last, ld_rel;
	logic                  vset, vclr, adv;

	// Shared tag adder: tag distance on acceptance, expected-tag increment on release.
	always_comb begin
		alu_a   = frame_tag;
		alu_b   = ~expected_q;
		alu_cin = 1'b1;
		if (state_q == iofr_pkg::ST_EMIT) begin
			alu_a = expected_q;
			alu_b = '0;
		end
	end

	assign alu_sum = alu_a + alu_b + {{(TAG_W - 1){1'b0}}, alu_cin};

	// Slot of the arriving tag, reduced modulo WINDOW with one compare and subtract.
	assign slot_sum = {1'b0, head_q} + {1'b0, dist_q[SLOT_W-1:0]};
	assign slot_idx = (slot_sum >= WIN_EXT) ? SLOT_W'(slot_sum - WIN_EXT)
	                                        : slot_sum[SLOT_W-1:0];
	assign head_nxt = (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != iofr_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Sequencer next state and control.
	always_comb begin
		state_d       = state_q;
		pend_status_d = pend_status_q;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		ld_out        = 1'b0;
		ld_status     = pend_status_q;
		ld_last       = 1'b1;
		ld_rel        = 1'b0;
		vset          = 1'b0;
		vclr          = 1'b0;
		adv           = 1'b0;
		unique case (state_q)
			iofr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = iofr_pkg::ST_EVAL;
				end
			end
			iofr_pkg::ST_EVAL: begin
				if (dist_q >= WIN_TAG) begin
					pend_status_d = iofr_pkg::STS_OUTSIDE;
					state_d       = iofr_pkg::ST_RESULT;
				end else if (valid_q[slot_idx]) begin
					pend_status_d = iofr_pkg::STS_DUPLICATE;
					state_d       = iofr_pkg::ST_RESULT;
				end else begin
					mem_we = 1'b1;
					vset   = 1'b1;
					// Only a frame at the expected tag can start a run.
					if (dist_q == '0) begin
						state_d = iofr_pkg::ST_READ;
					end else begin
						pend_status_d = iofr_pkg::STS_HELD;
						state_d       = iofr_pkg::ST_RESULT;
					end
				end
			end
			iofr_pkg::ST_READ: begin
				mem_re  = 1'b1;
				state_d = iofr_pkg::ST_EMIT;
			end
			iofr_pkg::ST_EMIT: begin
				ld_status = iofr_pkg::STS_RELEASED;
				ld_rel    = 1'b1;
				ld_last   = !valid_q[head_nxt];
				if (out_free) begin
					ld_out  = 1'b1;
					vclr    = 1'b1;
					adv     = 1'b1;
					state_d = ld_last ? iofr_pkg::ST_IDLE : iofr_pkg::ST_READ;
				end
			end
			iofr_pkg::ST_RESULT: begin
				if (out_free) begin
					ld_out  = 1'b1;
					state_d = iofr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = iofr_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= iofr_pkg::ST_IDLE;
			pend_status_q <= iofr_pkg::STS_HELD;
			expected_q    <= '0;
			head_q        <= '0;
			valid_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			pend_status_q <= pend_status_d;
			if (adv) begin
				expected_q <= alu_sum;
				head_q     <= head_nxt;
			end
			if (vset) begin
				valid_q[slot_idx] <= 1'b1;
			end
			if (vclr) begin
				valid_q[head_q] <= 1'b0;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input capture and output payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q  <= frame_tag;
			data_q <= frame_data[STORE_BITS-1:0];
			dist_q <= alu_sum;
		end
		if (ld_out) begin
			status_q   <= ld_status;
			out_tag_q  <= ld_rel ? expected_q : tag_q;
			out_data_q <= ld_rel ? FRAME_W'(rd_data) : '0;
			last_q     <= ld_last;
		end
	end

	// Slot payload storage.
	iofr_slot_mem #(
		.DEPTH (WINDOW),
		.WIDTH (STORE_BITS)
	) u_slot_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (slot_idx),
		.wr_data (data_q),
		.rd_en   (mem_re),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_tag   = out_tag_q;
	assign out_data  = out_data_q;
	assign last      = last_q;

	// Checks on the sequencer and release bookkeeping.
	`include "in_order_frame_release_unit_assert.svh"

	`IOFR_ASSERT_IMP(a_head_clear_at_idle, state_q == iofr_pkg::ST_IDLE, !valid_q[head_q])
	`IOFR_ASSERT_IMP(a_zero_data_on_status, out_valid_q && (status_q != iofr_pkg::STS_RELEASED), out_data_q == '0)
	`IOFR_ASSERT_NXT(a_expected_steps_by_one, adv, expected_q == TAG_W'($past(expected_q) + 1'b1))

endmodule
